[design/vgm_pkg.sv]
// Shared types and constants for the VGM command stream decoder.
package vgm_pkg;

   // Result kinds
   localparam logic [2:0] KIND_PSG  = 3'd0;
   localparam logic [2:0] KIND_FM   = 3'd1;
   localparam logic [2:0] KIND_WAIT = 3'd2;
   localparam logic [2:0] KIND_END  = 3'd3;
   localparam logic [2:0] KIND_ERR  = 3'd4;

   // Command bytes
   localparam logic [7:0] CMD_PSG       = 8'h50;
   localparam logic [7:0] CMD_FM        = 8'h51;
   localparam logic [7:0] CMD_WAIT_N    = 8'h61;
   localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
   localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
   localparam logic [7:0] CMD_END       = 8'h66;
   localparam logic [7:0] CMD_SKIP1     = 8'h4f;
   localparam logic [7:0] CMD_SHORT_LO  = 8'h6f;
   localparam logic [7:0] CMD_SHORT_HI  = 8'h80;

   // samples / 735 == (samples * 91305) >> 26 for any 16-bit sample count
   localparam int unsigned SAMPLES_PER_FRAME = 735;
   localparam int unsigned RECIP_SHIFT       = 26;
   localparam logic [16:0] RECIP_735         = 17'd91305;

   localparam logic [31:0] DATA_SIZE_RESET = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] fm_register;
      logic [7:0] data_value;
      logic [6:0] wait_frames;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] stream_byte;
   } req_word_type;

endpackage

[design/vgm_in_stage.sv]
// Input register stage: holds one stream byte until the decoder takes it.
module vgm_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_stream_byte,
   input  logic                  take,
   output vgm_pkg::req_word_type word_out
);
   import vgm_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_stream_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign word_out.valid       = valid_ff;
   assign word_out.stream_byte = byte_ff;

endmodule

[design/vgm_decode_core.sv]
// Command decode state, data size register and result register.
module vgm_decode_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   input  vgm_pkg::req_word_type word_in,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output vgm_pkg::rsp_word_type rsp_word
);
   import vgm_pkg::*;

   typedef enum logic [2:0] {
      PH_CMD     = 3'd0,
      PH_PSG     = 3'd1,
      PH_FM_REG  = 3'd2,
      PH_FM_DATA = 3'd3,
      PH_WAIT_LO = 3'd4,
      PH_WAIT_HI = 3'd5,
      PH_SKIP    = 3'd6
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [7:0]   held_reg_ff, held_reg_in;
   logic [7:0]   held_lo_ff, held_lo_in;
   logic [31:0]  count_ff, count_in;
   logic         stopped_ff, stopped_in;
   logic [31:0]  data_size_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_ff, out_in;

   logic [7:0]   b;
   logic [15:0]  samples;
   logic [32:0]  prod;
   logic [6:0]   frames;
   logic         emit;
   rsp_word_type res;

   assign take = word_in.valid && (!out_valid_ff || rsp_ready);
   assign b    = word_in.stream_byte;

   assign samples = {b, held_lo_ff};
   assign prod    = {17'd0, samples} * {16'd0, RECIP_735};
   assign frames  = prod[32:RECIP_SHIFT] + 7'd1;

   always_comb begin
      phase_in    = phase_ff;
      held_reg_in = held_reg_ff;
      held_lo_in  = held_lo_ff;
      count_in    = count_ff;
      stopped_in  = stopped_ff;
      emit        = 1'b0;
      res         = '0;

      if (take && !stopped_ff) begin
         if (count_ff >= data_size_ff) begin
            stopped_in = 1'b1;
            emit       = 1'b1;
            res.kind   = KIND_END;
         end else begin
            phase_in = PH_CMD;
            case (phase_ff)
               PH_PSG: begin
                  count_in       = count_ff + 32'd2;
                  emit           = 1'b1;
                  res.kind       = KIND_PSG;
                  res.data_value = b;
               end
               PH_FM_REG: begin
                  held_reg_in = b;
                  phase_in    = PH_FM_DATA;
               end
               PH_FM_DATA: begin
                  count_in        = count_ff + 32'd3;
                  emit            = 1'b1;
                  res.kind        = KIND_FM;
                  res.fm_register = held_reg_ff;
                  res.data_value  = b;
               end
               PH_WAIT_LO: begin
                  held_lo_in = b;
                  phase_in   = PH_WAIT_HI;
               end
               PH_WAIT_HI: begin
                  count_in        = count_ff + 32'd3;
                  emit            = 1'b1;
                  res.kind        = KIND_WAIT;
                  res.wait_frames = frames;
               end
               PH_SKIP: begin
                  count_in = count_ff + 32'd2;
               end
               default: begin
                  // command byte; the unused phase code lands here too
                  case (b)
                     CMD_PSG:    phase_in = PH_PSG;
                     CMD_FM:     phase_in = PH_FM_REG;
                     CMD_WAIT_N: phase_in = PH_WAIT_LO;
                     CMD_SKIP1:  phase_in = PH_SKIP;
                     CMD_WAIT_NTSC, CMD_WAIT_PAL: begin
                        count_in        = count_ff + 32'd1;
                        emit            = 1'b1;
                        res.kind        = KIND_WAIT;
                        res.wait_frames = 7'd1;
                     end
                     CMD_END: begin
                        stopped_in = 1'b1;
                        emit       = 1'b1;
                        res.kind   = KIND_END;
                     end
                     default: begin
                        if (b > CMD_SHORT_LO && b < CMD_SHORT_HI) begin
                           count_in = count_ff + 32'd1;
                        end else begin
                           stopped_in     = 1'b1;
                           emit           = 1'b1;
                           res.kind       = KIND_ERR;
                           res.data_value = b;
                        end
                     end
                  endcase
               end
            endcase
         end
      end

      out_in = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = res;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CMD;
         held_reg_ff  <= 8'd0;
         held_lo_ff   <= 8'd0;
         count_ff     <= 32'd0;
         stopped_ff   <= 1'b0;
         data_size_ff <= DATA_SIZE_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         held_reg_ff  <= held_reg_in;
         held_lo_ff   <= held_lo_in;
         count_ff     <= count_in;
         stopped_ff   <= stopped_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr_en) begin
            data_size_ff <= csr_wr_data;
         end
      end
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

endmodule

[design/vgm_command_stream_decoder.sv]
// VGM command stream decoder: one stream byte per word, at most one result per command.
// Throughput is one stream byte per clock cycle with no bubbles while the result register
// is not stalled; a byte is decoded out of the input register into the result register,
// which offers any result word that it yields. A stall on rsp_ready holds the result
// register and backs up into the input register, so req_ready drops only when both hold a
// word.
module vgm_command_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_fm_register,
   output logic [7:0]  rsp_data_value,
   output logic [6:0]  rsp_wait_frames
);
   import vgm_pkg::*;

   req_word_type req_word;
   rsp_word_type rsp_word;
   logic         take;

   vgm_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .take            (take),
      .word_out        (req_word)
   );

   vgm_decode_core u_decode_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .word_in     (req_word),
      .take        (take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

   assign rsp_kind        = rsp_word.kind;
   assign rsp_fm_register = rsp_word.fm_register;
   assign rsp_data_value  = rsp_word.data_value;
   assign rsp_wait_frames = rsp_word.wait_frames;

endmodule

[design/vgm_checker.sv]
// Port-level checker for the VGM command stream decoder, bound to the top level.
module vgm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [7:0]  rsp_fm_register,
   input logic [7:0]  rsp_data_value,
   input logic [6:0]  rsp_wait_frames
);
   import vgm_pkg::*;

   // a stalled result word holds its kind, data value and wait frames
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_value) && $stable(rsp_wait_frames))
      else $error("result word changed while stalled");

   // end or error latches the block silent
   a_silent_after_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_kind == KIND_END || rsp_kind == KIND_ERR)
         |=> !rsp_valid)
      else $error("result after end or error");

   a_wait_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WAIT |-> rsp_wait_frames != 7'd0
         && rsp_wait_frames <= 7'd90 && rsp_data_value == 8'd0)
      else $error("wait word out of range");

   a_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_WAIT |-> rsp_wait_frames == 7'd0
         && (rsp_kind == KIND_FM || rsp_fm_register == 8'd0))
      else $error("unused result fields not zero");

endmodule

bind vgm_command_stream_decoder vgm_checker u_vgm_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_kind        (rsp_kind),
   .rsp_fm_register (rsp_fm_register),
   .rsp_data_value  (rsp_data_value),
   .rsp_wait_frames (rsp_wait_frames)
);

[sim/tb.sv]
// Self-checking testbench for the VGM command stream decoder.
`timescale 1ns / 100ps

module tb;
   import vgm_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES   = 480;
   localparam int HOLD_AT       = 120;
   localparam int HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {
      FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH
   } flow_mode_type;

   typedef enum logic [2:0] {
      ST_COMMAND, ST_PSG_DATA, ST_FM_REGISTER, ST_FM_DATA, ST_WAIT_LO, ST_WAIT_HI, ST_SKIP
   } decode_state_type;

   typedef enum logic [1:0] {
      STOP_END_CMD, STOP_BAD_CMD, STOP_SIZE_BOUNDARY, STOP_SIZE_MID
   } stop_how_type;

   // short directed stream: field extremes, every non-terminating command, wait rounding edge
   localparam logic [7:0] DIRECTED [25] = '{
      CMD_PSG, 8'h00,
      CMD_PSG, CMD_FM,
      CMD_FM, 8'hFF, 8'h00,
      CMD_FM, 8'h00, 8'hFF,
      CMD_WAIT_N, 8'h00, 8'h00,
      CMD_WAIT_N, 8'hFF, 8'hFF,
      CMD_WAIT_N, 8'hDF, 8'h02,
      CMD_WAIT_NTSC, CMD_WAIT_PAL,
      CMD_SKIP1, CMD_END,
      CMD_SHORT_LO + 8'd1, CMD_SHORT_HI - 8'd1
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_fm_register;
   logic [7:0]  rsp_data_value;
   logic [6:0]  rsp_wait_frames;

   vgm_command_stream_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_fm_register (rsp_fm_register),
      .rsp_data_value  (rsp_data_value),
      .rsp_wait_frames (rsp_wait_frames)
   );

   logic [7:0]    byte_queue [$];
   rsp_word_type  pending_results [$];
   flow_mode_type flow_mode = FLOW_FREE;
   int            words_sent = 0;
   int            error_count = 0;
   int            kind_seen [5] = '{default: 0};
   int            hold_left = 0;
   bit            hold_done = 1'b0;

   // decoder state as predicted from the accepted words
   decode_state_type dec_state = ST_COMMAND;
   logic [7:0]       fm_reg_hold = '0;
   logic [7:0]       wait_lo_hold = '0;
   logic [31:0]      bytes_done = '0;
   logic [31:0]      size_limit = DATA_SIZE_RESET;
   bit               halted = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic decode_predict(input logic [7:0] b);
      rsp_word_type r;
      bit           emit;
      logic [15:0]  samples;
      r = '0;
      emit = 1'b0;
      if (halted) return;
      if (bytes_done >= size_limit) begin
         halted = 1'b1;
         r.kind = KIND_END;
         emit = 1'b1;
      end else begin
         case (dec_state)
            ST_PSG_DATA: begin
               dec_state = ST_COMMAND;
               bytes_done += 2;
               r.kind = KIND_PSG;
               r.data_value = b;
               emit = 1'b1;
            end
            ST_FM_REGISTER: begin
               fm_reg_hold = b;
               dec_state = ST_FM_DATA;
            end
            ST_FM_DATA: begin
               dec_state = ST_COMMAND;
               bytes_done += 3;
               r.kind = KIND_FM;
               r.fm_register = fm_reg_hold;
               r.data_value = b;
               emit = 1'b1;
            end
            ST_WAIT_LO: begin
               wait_lo_hold = b;
               dec_state = ST_WAIT_HI;
            end
            ST_WAIT_HI: begin
               dec_state = ST_COMMAND;
               bytes_done += 3;
               samples = {b, wait_lo_hold};
               r.kind = KIND_WAIT;
               r.wait_frames = 7'(samples / SAMPLES_PER_FRAME + 1);
               emit = 1'b1;
            end
            ST_SKIP: begin
               dec_state = ST_COMMAND;
               bytes_done += 2;
            end
            default: begin
               dec_state = ST_COMMAND;
               case (b)
                  CMD_PSG:    dec_state = ST_PSG_DATA;
                  CMD_FM:     dec_state = ST_FM_REGISTER;
                  CMD_WAIT_N: dec_state = ST_WAIT_LO;
                  CMD_SKIP1:  dec_state = ST_SKIP;
                  CMD_WAIT_NTSC, CMD_WAIT_PAL: begin
                     bytes_done += 1;
                     r.kind = KIND_WAIT;
                     r.wait_frames = 7'd1;
                     emit = 1'b1;
                  end
                  CMD_END: begin
                     halted = 1'b1;
                     r.kind = KIND_END;
                     emit = 1'b1;
                  end
                  default: begin
                     if (b > CMD_SHORT_LO && b < CMD_SHORT_HI) begin
                        bytes_done += 1;
                     end else begin
                        halted = 1'b1;
                        r.kind = KIND_ERR;
                        r.data_value = b;
                        emit = 1'b1;
                     end
                  end
               endcase
            end
         endcase
      end
      if (emit) pending_results.push_back(r);
   endtask

   // one well-formed, non-terminating command with random content
   function automatic int push_random_command();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 25) begin
         byte_queue.push_back(CMD_PSG);
         byte_queue.push_back(8'($urandom));
         return 2;
      end else if (pick < 50) begin
         byte_queue.push_back(CMD_FM);
         byte_queue.push_back(8'($urandom));
         byte_queue.push_back(8'($urandom));
         return 3;
      end else if (pick < 70) begin
         byte_queue.push_back(CMD_WAIT_N);
         byte_queue.push_back(8'($urandom));
         byte_queue.push_back(8'($urandom));
         return 3;
      end else if (pick < 80) begin
         byte_queue.push_back($urandom_range(1, 0) ? CMD_WAIT_NTSC : CMD_WAIT_PAL);
         return 1;
      end else if (pick < 90) begin
         byte_queue.push_back(CMD_SKIP1);
         byte_queue.push_back(8'($urandom));
         return 2;
      end
      byte_queue.push_back(8'($urandom_range(CMD_SHORT_HI - 8'd1, CMD_SHORT_LO + 8'd1)));
      return 1;
   endfunction

   task automatic wait_quiet();
      while (byte_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(negedge clock);
      // a word with no result may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_data_size(input logic [31:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      size_limit = value;
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_predict(req_stream_byte);
            words_sent <= words_sent + 1;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() != 0 &&
                $urandom_range(99, 0) >= (flow_mode == FLOW_SENDER_IDLE ? 57 :
                                          flow_mode == FLOW_BOTH ? 19 : 0)) begin
               req_valid <= 1'b1;
               req_stream_byte <= byte_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver hold-off so the pipe fills and req_ready drops
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && words_sent == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_kind <= KIND_ERR) kind_seen[rsp_kind]++;
            if (pending_results.size() == 0) begin
               report_mismatch("word with nothing expected, kind", rsp_kind, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_fm_register !== want.fm_register)
                  report_mismatch("fm_register", rsp_fm_register, want.fm_register);
               if (rsp_data_value !== want.data_value)
                  report_mismatch("data_value", rsp_data_value, want.data_value);
               if (rsp_wait_frames !== want.wait_frames)
                  report_mismatch("wait_frames", rsp_wait_frames, want.wait_frames);
            end
         end
         rsp_ready <= hold_left == 0 &&
                      $urandom_range(99, 0) >= (flow_mode == FLOW_RECEIVER_STALL ? 57 :
                                                flow_mode == FLOW_BOTH ? 19 : 0);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      flow_mode_type modes [4];
      stop_how_type  stop_how;
      logic [7:0]    b;
      rsp_word_type  left;
      int            queued;
      int            drain;
      modes = '{FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_data_size(32'hFFFF_FFFF);
      foreach (DIRECTED[i]) byte_queue.push_back(DIRECTED[i]);

      foreach (modes[m]) begin
         flow_mode = modes[m];
         queued = 0;
         while (queued < PHASE_BYTES) queued += push_random_command();
         wait_quiet();
         write_data_size($urandom_range(32'hFFFF_FFFE, bytes_done + 32'd100000));
      end

      // the block latches silent after one end or error, so one way to stop per run
      stop_how = stop_how_type'($urandom_range(3, 0));
      case (stop_how)
         STOP_END_CMD: byte_queue.push_back(CMD_END);
         STOP_BAD_CMD: begin
            if ($urandom_range(1, 0)) begin
               case ($urandom_range(3, 0))
                  0: b = CMD_SHORT_LO;
                  1: b = CMD_SHORT_HI;
                  2: b = 8'h00;
                  default: b = 8'hFF;
               endcase
            end else begin
               do b = 8'($urandom);
               while (b == CMD_PSG || b == CMD_FM || b == CMD_WAIT_N ||
                      b == CMD_WAIT_NTSC || b == CMD_WAIT_PAL || b == CMD_END ||
                      b == CMD_SKIP1 || (b > CMD_SHORT_LO && b < CMD_SHORT_HI));
            end
            byte_queue.push_back(b);
         end
         STOP_SIZE_BOUNDARY: write_data_size(bytes_done + $urandom_range(8, 0));
         default: begin
            // cut the size while a command is half way in
            case ($urandom_range(3, 0))
               0: byte_queue.push_back(CMD_PSG);
               1: byte_queue.push_back(CMD_SKIP1);
               2: begin
                  byte_queue.push_back(CMD_FM);
                  if ($urandom_range(1, 0)) byte_queue.push_back(8'($urandom));
               end
               default: begin
                  byte_queue.push_back(CMD_WAIT_N);
                  if ($urandom_range(1, 0)) byte_queue.push_back(8'($urandom));
               end
            endcase
            wait_quiet();
            write_data_size($urandom_range(1, 0) ? 32'd0 : $urandom_range(bytes_done, 0));
         end
      endcase
      repeat (10) void'(push_random_command());
      wait_quiet();

      // stopped: nothing more may come out, whatever the size says
      write_data_size(32'd0);
      repeat (8) byte_queue.push_back(8'($urandom));

      while (byte_queue.size() != 0 || req_valid) @(negedge clock);
      drain = 0;
      while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (pending_results.size() != 0) begin
         left = pending_results.pop_front();
         report_mismatch("word never came, kind", 0, left.kind);
      end

      $display("%0d stream bytes sent; words checked: %0d psg, %0d fm, %0d wait,",
               words_sent, kind_seen[KIND_PSG], kind_seen[KIND_FM], kind_seen[KIND_WAIT]);
      $display("%0d end, %0d error; stream stopped by %s, %0d mismatches",
               kind_seen[KIND_END], kind_seen[KIND_ERR], stop_how.name(), error_count);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[vgm_command_stream_decoder.f]
design/vgm_pkg.sv
design/vgm_in_stage.sv
design/vgm_decode_core.sv
design/vgm_command_stream_decoder.sv
design/vgm_checker.sv
sim/tb.sv
